/* src/arp_pkg.sv */
// arp_pkg: shared types and constants of the address-resolution cache
// used by arp_cache_engine; depends on nothing else
package arp_pkg;

  localparam int unsigned DEF_ENTRIES = 32;

  localparam logic [15:0] RESET_PENDING_LIFE  = 16'd20;
  localparam logic [19:0] RESET_RESOLVED_LIFE = 20'd6000;

  localparam logic [15:0] HW_TYPE_ETH   = 16'd1;
  localparam logic [15:0] PROTO_IPV4    = 16'h0800;
  localparam logic [7:0]  HW_LEN_ETH    = 8'd6;
  localparam logic [7:0]  PROTO_LEN_IP4 = 8'd4;
  localparam logic [15:0] OP_REQUEST    = 16'd1;

  // configuration register indexes
  localparam logic [1:0] REG_PENDING_LIFE  = 2'd0;
  localparam logic [1:0] REG_RESOLVED_LIFE = 2'd1;

  // item kinds
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_RESOLVE = 2'd1;
  localparam logic [1:0] KIND_FRAME   = 2'd2;

  // result status codes
  localparam logic [2:0] STAT_HIT      = 3'd0;
  localparam logic [2:0] STAT_SELF     = 3'd1;
  localparam logic [2:0] STAT_WAITING  = 3'd2;
  localparam logic [2:0] STAT_FAILED   = 3'd3;
  localparam logic [2:0] STAT_LEARNED  = 3'd4;
  localparam logic [2:0] STAT_REJECTED = 3'd5;
  localparam logic [2:0] STAT_TICK     = 3'd6;

  // entry states
  localparam logic [1:0] ENT_FREE     = 2'd0;
  localparam logic [1:0] ENT_PENDING  = 2'd1;
  localparam logic [1:0] ENT_RESOLVED = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  iface;
    logic [31:0] ip_addr;
    logic [47:0] sender_mac;
    logic [31:0] target_ip;
    logic [15:0] opcode;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  hw_len;
    logic [7:0]  proto_len;
    logic        carries_packet;
    logic [31:0] local_ip;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] mac_addr;
    logic        send_request;
    logic        flush_queued;
    logic        free_queued;
    logic        send_reply;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  state;
    logic [3:0]  iface;
    logic [31:0] ip;
    logic [47:0] mac;
    logic [31:0] expiry;
    logic        queued;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CLEAR  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_FETCH  = 5'b01000,
    S_UPDATE = 5'b10000
  } fsm_t;

endpackage

/* src/arp_cache_engine.sv */
// arp_cache_engine: address-resolution cache with one entry memory and a scan sequencer
// depends on arp_pkg
//
//  channel   signals                              transfer at
//  item      start, busy, item                    start && !busy
//  result    done, result                         every cycle done is high
//  config    cfg_valid, cfg_ready, cfg_index,     cfg_valid && cfg_ready
//            cfg_data
//
// ticks, unused kinds, self addresses and bad frames answer in the cycle after
// transfer. resolves and good frames scan the entry memory one entry a cycle
// (one read port), then read, modify and write the chosen entry (no write when
// a resolve hits); busy stays high until the result appears. after reset a
// clearing pass over all ENTRIES entries holds busy high. results cannot be
// stalled; config is always ready.
module arp_cache_engine #(
  parameter int unsigned ENTRIES = arp_pkg::DEF_ENTRIES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  arp_pkg::in_item_t item,
  output logic              done,
  output arp_pkg::out_item_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [19:0]       cfg_data
);
  import arp_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

  fsm_t state;
  in_item_t cur;
  logic [31:0] tick;
  logic [15:0] pending_life;
  logic [19:0] resolved_life;

  entry_t mem [ENTRIES];
  entry_t rdata;
  entry_t wdata;
  logic [IDX_W-1:0] raddr, waddr;
  logic we;

  logic [CNT_W-1:0] cnt;
  logic rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic found, has_free;
  logic [IDX_W-1:0] found_idx, free_idx, min_idx, target;
  logic [31:0] min_exp;

  // entry memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= (state == S_CLEAR) ? '0 : wdata;
    end
    rdata <= mem[raddr];
  end

  assign cfg_ready = 1'b1;
  assign busy = (state != S_IDLE);
  assign target = found ? found_idx : (has_free ? free_idx : min_idx);
  assign raddr = (state == S_FETCH) ? target : cnt[IDX_W-1:0];

  // header check and self match for the item on the port
  logic frame_ok, self_hit, needs_scan;
  assign frame_ok = (item.hw_type == HW_TYPE_ETH) && (item.proto_type == PROTO_IPV4) &&
                    (item.hw_len == HW_LEN_ETH) && (item.proto_len == PROTO_LEN_IP4);
  assign self_hit = (item.ip_addr == item.local_ip);
  assign needs_scan = (item.kind == KIND_RESOLVE && !self_hit) ||
                      (item.kind == KIND_FRAME && frame_ok);

  // answer for items that need no scan
  out_item_t quick_res;
  always_comb begin
    quick_res = '0;
    quick_res.status = STAT_REJECTED;
    if (item.kind == KIND_TICK) begin
      quick_res.status = STAT_TICK;
    end else if (item.kind == KIND_RESOLVE && self_hit) begin
      quick_res.status = STAT_SELF;
    end
  end

  // entry update for the chosen entry
  entry_t eff;
  out_item_t upd_res;
  logic hit, need, q;
  always_comb begin
    eff = found ? rdata : '0;
    upd_res = '0;
    wdata = '0;
    hit = found && (rdata.state == ENT_RESOLVED) && (rdata.expiry > tick);
    need = eff.expiry <= tick;
    q = eff.queued;
    upd_res.free_queued = !found && !has_free && rdata.queued;
    if (cur.kind == KIND_FRAME) begin
      wdata.state  = ENT_RESOLVED;
      wdata.iface  = cur.iface;
      wdata.ip     = cur.ip_addr;
      wdata.mac    = cur.sender_mac;
      wdata.expiry = tick + {12'd0, resolved_life};
      wdata.queued = 1'b0;
      upd_res.status = STAT_LEARNED;
      upd_res.flush_queued = eff.queued;
      upd_res.send_reply = (cur.opcode == OP_REQUEST) && (cur.local_ip != 32'd0) &&
                           (cur.target_ip == cur.local_ip);
    end else if (hit) begin
      upd_res.status = STAT_HIT;
      upd_res.mac_addr = rdata.mac;
    end else begin
      if (cur.carries_packet) begin
        if (q) begin
          upd_res.free_queued = 1'b1;
        end
        q = 1'b1;
      end
      wdata.mac = eff.mac;
      if (need && cur.local_ip == 32'd0) begin
        if (q && !cur.carries_packet) begin
          upd_res.free_queued = 1'b1;
        end
        wdata.state = ENT_FREE;
        upd_res.status = STAT_FAILED;
      end else begin
        wdata.state  = ENT_PENDING;
        wdata.iface  = cur.iface;
        wdata.ip     = cur.ip_addr;
        wdata.expiry = tick + {16'd0, pending_life};
        wdata.queued = q;
        upd_res.status = STAT_WAITING;
        upd_res.send_request = need;
      end
    end
  end

  always_comb begin
    we = 1'b0;
    waddr = target;
    if (state == S_CLEAR) begin
      we = 1'b1;
      waddr = cnt[IDX_W-1:0];
    end else if (state == S_UPDATE) begin
      we = !(cur.kind == KIND_RESOLVE && hit);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_life  <= RESET_PENDING_LIFE;
      resolved_life <= RESET_RESOLVED_LIFE;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_PENDING_LIFE) begin
        pending_life <= cfg_data[15:0];
      end else if (cfg_index == REG_RESOLVED_LIFE) begin
        resolved_life <= cfg_data;
      end
    end
  end

  // result strobe after a quick answer or an update
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == S_IDLE && start && !needs_scan) || (state == S_UPDATE);
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      cnt     <= '0;
      tick    <= '0;
      rd_pend <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          if (cnt == LAST_CNT - 1'b1) begin
            state <= S_IDLE;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_IDLE: begin
          if (start) begin
            cur <= item;
            if (item.kind == KIND_TICK) begin
              tick <= tick + 32'd1;
            end
            if (needs_scan) begin
              state    <= S_SCAN;
              cnt      <= '0;
              rd_pend  <= 1'b0;
              found    <= 1'b0;
              has_free <= 1'b0;
            end else begin
              result <= quick_res;
            end
          end
        end
        S_SCAN: begin
          // issue one read a cycle, check the data of the previous one
          rd_pend <= (cnt != LAST_CNT);
          rd_idx  <= cnt[IDX_W-1:0];
          if (cnt != LAST_CNT) begin
            cnt <= cnt + 1'b1;
          end
          if (rd_pend) begin
            if (!found && rdata.state != ENT_FREE && rdata.iface == cur.iface &&
                rdata.ip == cur.ip_addr) begin
              found     <= 1'b1;
              found_idx <= rd_idx;
            end
            if (!has_free && rdata.state == ENT_FREE) begin
              has_free <= 1'b1;
              free_idx <= rd_idx;
            end
            if (rd_idx == '0 || rdata.expiry < min_exp) begin
              min_exp <= rdata.expiry;
              min_idx <= rd_idx;
            end
          end else if (cnt == LAST_CNT) begin
            state <= S_FETCH;
          end
        end
        S_FETCH: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          result <= upd_res;
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_update_answers: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE) |=> (done && !busy))
    else $error("update did not produce a result");

  a_request_waiting: assert property (@(posedge clk) disable iff (rst)
    (done && result.send_request) |-> (result.status == STAT_WAITING))
    else $error("request outside waiting result");

  a_mac_only_hit: assert property (@(posedge clk) disable iff (rst)
    (done && result.status != STAT_HIT) |-> (result.mac_addr == 48'd0))
    else $error("mac on a non-hit result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_SCAN) |-> !we)
    else $error("memory write outside clear or update");
`endif

endmodule
